>>> hdl/assert_macros.svh
// assertion macros shared by the waveform column min/max rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/wcmm_pkg.sv
// types, constants and helpers for the waveform column min/max block
// no dependencies
`timescale 1ns / 1ps

package wcmm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int CNT_BITS     = 4;
  localparam int Y_BITS       = 12;
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int SHIFT_BITS   = SUM_BITS + 2;
  localparam int POS_BITS     = SUM_BITS + 1;
  localparam int PROD_BITS    = POS_BITS + Y_BITS;
  localparam int DEN_BITS     = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int Q_BITS       = Y_BITS + $clog2(MAX_CHANNELS);
  localparam int STEP_BITS    = $clog2(Q_BITS);
  localparam int DIV_BITS     = DEN_BITS + Q_BITS - 1;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT_BOUND  = CFG_IDX_BITS'(1);

  localparam logic [CNT_BITS-1:0] CHANNEL_COUNT_RESET = CNT_BITS'(1);
  localparam logic [Y_BITS-1:0]   HEIGHT_BOUND_RESET  = Y_BITS'(255);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef struct packed {
    logic start;
    sum_t min_sum;
    sum_t max_sum;
  } column_end_t;

  function automatic logic [CNT_BITS-1:0] eff_count(input logic [CNT_BITS-1:0] raw);
    logic [CNT_BITS-1:0] n;
    n = raw;
    if (n == '0) begin
      n = CNT_BITS'(1);
    end
    if (n > CNT_BITS'(MAX_CHANNELS)) begin
      n = CNT_BITS'(MAX_CHANNELS);
    end
    return n;
  endfunction

endpackage

>>> hdl/wcmm_if.sv
// channel interfaces: frame input, column result output, register writes
// depends on wcmm_pkg
`timescale 1ns / 1ps

interface wcmm_frame_if import wcmm_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  sample_t sample_ch4;
  sample_t sample_ch5;
  sample_t sample_ch6;
  sample_t sample_ch7;
  logic    last_in_column;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    output sample_ch4, sample_ch5, sample_ch6, sample_ch7, last_in_column,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    input  sample_ch4, sample_ch5, sample_ch6, sample_ch7, last_in_column,
    output ready
  );
endinterface

interface wcmm_result_if import wcmm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [Y_BITS-1:0] y_of_min;
  logic [Y_BITS-1:0] y_of_max;

  modport source (output valid, y_of_min, y_of_max, input ready);
  modport sink (input valid, y_of_min, y_of_max, output ready);
endinterface

interface wcmm_cfg_if import wcmm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/wcmm_lane.sv
// one channel lane: masks an inactive channel and registers the sample
// depends on wcmm_pkg
`timescale 1ns / 1ps

module wcmm_lane import wcmm_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  logic    active,
  input  sample_t sample,
  output sample_t value
);

  always_ff @(posedge clk) begin
    if (load) begin
      value <= active ? sample : '0;
    end
  end

endmodule

>>> hdl/wcmm_merge.sv
// merge stage: sums the lanes and tracks the column's min and max frame sum
// depends on wcmm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wcmm_merge import wcmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        beat,
  input  logic        last,
  input  sample_t     lane_val [MAX_CHANNELS],
  output column_end_t col
);

  sum_t frame_sum;
  sum_t min_sum;
  sum_t max_sum;
  sum_t min_next;
  sum_t max_next;
  logic column_open;

  always_comb begin
    frame_sum = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      frame_sum = frame_sum + SUM_BITS'(lane_val[i]);
    end
  end

  always_comb begin
    min_next = (!column_open || frame_sum < min_sum) ? frame_sum : min_sum;
    max_next = (!column_open || frame_sum > max_sum) ? frame_sum : max_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_open <= 1'b0;
      min_sum     <= '0;
      max_sum     <= '0;
    end else if (beat) begin
      column_open <= !last;
      min_sum     <= min_next;
      max_sum     <= max_next;
    end
  end

  assign col.start   = beat && last;
  assign col.min_sum = min_next;
  assign col.max_sum = max_next;

  `ASSERT_SAME(a_min_le_max, clk, rst, column_open, min_sum <= max_sum)
  `ASSERT_NEXT(a_last_closes, clk, rst, beat && last, !column_open)

endmodule

>>> hdl/wcmm_scale.sv
// y scaling unit: offset, multiply by height, restoring divide by 65535*n
// depends on wcmm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wcmm_scale import wcmm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sum_t                sum,
  input  logic [CNT_BITS-1:0] n,
  input  logic [Y_BITS-1:0]   h,
  input  logic                take,
  output logic                done,
  output logic [Y_BITS-1:0]   y
);

  scale_state_t state;
  scale_state_t state_next;

  logic [POS_BITS-1:0]   pos;
  logic [Y_BITS-1:0]     h_q;
  logic [DEN_BITS-1:0]   den;
  logic [PROD_BITS-1:0]  rem;
  logic [Q_BITS-1:0]     quot;
  logic [STEP_BITS-1:0]  step;

  logic [SHIFT_BITS-1:0] shifted;
  logic [SHIFT_BITS-1:0] offset;
  logic [POS_BITS-1:0]   pos_next;
  logic [DEN_BITS-1:0]   den_next;
  logic [DIV_BITS-1:0]   trial;
  logic                  fits;

  always_comb begin
    offset   = SHIFT_BITS'(n) << (SAMPLE_BITS - 1);
    shifted  = {{(SHIFT_BITS - SUM_BITS){sum[SUM_BITS-1]}}, sum} + offset;
    pos_next = (!shifted[SHIFT_BITS-1] && shifted != '0) ? shifted[POS_BITS-1:0] : '0;
    den_next = (DEN_BITS'(n) << SAMPLE_BITS) - DEN_BITS'(n);
    trial    = DIV_BITS'(den) << step;
    fits     = DIV_BITS'(rem) >= trial;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_MUL;
      SC_MUL:  state_next = SC_DIV;
      SC_DIV:  if (step == '0) state_next = SC_DONE;
      SC_DONE: if (take) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    done = (state == SC_DONE);
    y    = (quot > Q_BITS'(h_q)) ? h_q : quot[Y_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        if (start) begin
          pos <= pos_next;
          den <= den_next;
          h_q <= h;
        end
      end
      SC_MUL: begin
        rem  <= PROD_BITS'(pos) * PROD_BITS'(h_q);
        quot <= '0;
        step <= STEP_BITS'(Q_BITS - 1);
      end
      SC_DIV: begin
        if (fits) begin
          rem <= PROD_BITS'(DIV_BITS'(rem) - trial);
        end
        quot[step] <= fits;
        step       <= step - STEP_BITS'(1);
      end
      SC_DONE: ;
      default: ;
    endcase
  end

  `ASSERT_SAME(a_start_when_idle, clk, rst, start, state == SC_IDLE)
  `ASSERT_NEXT(a_mul_then_div, clk, rst, state == SC_MUL, state == SC_DIV && quot == '0)

endmodule

>>> hdl/waveform_column_min_max.sv
// top level of the waveform column min/max block: lanes, merge, y scaling
// depends on wcmm_pkg, wcmm_if, wcmm_lane, wcmm_merge, wcmm_scale
//
//   channel  dir  width        beat carries
//   frame    in   8x16 + 1     channel samples, last_in_column
//   result   out  12 + 12      y_of_min, y_of_max
//   cfg      in   4 + 12       register index, write data
//
// frames that do not close a column are taken one per cycle while none is pending
// a column-closing frame blocks the frame channel until its result is taken:
// the lanes register it, then merge with scale setup, the multiply, the 15-step
// restoring divider, and the load of the result register
// a result still waiting in the output register delays that load and so
// stretches the stall; reset is synchronous and cfg writes are always ready
`timescale 1ns / 1ps
`include "assert_macros.svh"

module waveform_column_min_max import wcmm_pkg::*; (
  input logic         clk,
  input logic         rst,
  wcmm_frame_if.sink  frame,
  wcmm_result_if.source result,
  wcmm_cfg_if.sink    cfg
);

  logic [CNT_BITS-1:0] channel_count;
  logic [Y_BITS-1:0]   height_bound;
  logic [CNT_BITS-1:0] n_eff;

  logic        accept;
  logic        pend;
  logic        lane_beat;
  logic        lane_last;
  logic        take;
  logic        done_min;
  logic        done_max;
  logic [Y_BITS-1:0] y_min;
  logic [Y_BITS-1:0] y_max;

  sample_t     samples  [MAX_CHANNELS];
  sample_t     lane_val [MAX_CHANNELS];
  column_end_t col;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
      height_bound  <= HEIGHT_BOUND_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHANNEL_COUNT: channel_count <= cfg.data[CNT_BITS-1:0];
        REG_HEIGHT_BOUND:  height_bound  <= cfg.data[Y_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = eff_count(channel_count);

  assign samples[0] = frame.sample_ch0;
  assign samples[1] = frame.sample_ch1;
  assign samples[2] = frame.sample_ch2;
  assign samples[3] = frame.sample_ch3;
  assign samples[4] = frame.sample_ch4;
  assign samples[5] = frame.sample_ch5;
  assign samples[6] = frame.sample_ch6;
  assign samples[7] = frame.sample_ch7;

  assign frame.ready = !pend;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      lane_beat <= 1'b0;
    end else begin
      lane_beat <= accept;
      if (accept && frame.last_in_column) begin
        pend <= 1'b1;
      end else if (take) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lane_last <= frame.last_in_column;
    end
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    wcmm_lane u_lane (
      .clk    (clk),
      .load   (accept),
      .active (CNT_BITS'(c) < n_eff),
      .sample (samples[c]),
      .value  (lane_val[c])
    );
  end

  wcmm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .beat     (lane_beat),
    .last     (lane_last),
    .lane_val (lane_val),
    .col      (col)
  );

  wcmm_scale u_scale_min (
    .clk   (clk),
    .rst   (rst),
    .start (col.start),
    .sum   (col.min_sum),
    .n     (n_eff),
    .h     (height_bound),
    .take  (take),
    .done  (done_min),
    .y     (y_min)
  );

  wcmm_scale u_scale_max (
    .clk   (clk),
    .rst   (rst),
    .start (col.start),
    .sum   (col.max_sum),
    .n     (n_eff),
    .h     (height_bound),
    .take  (take),
    .done  (done_max),
    .y     (y_max)
  );

  assign take = done_min && done_max && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.y_of_min <= y_min;
      result.y_of_max <= y_max;
    end
  end

  `ASSERT_ALWAYS(a_scales_in_step, clk, rst, done_min == done_max)
  `ASSERT_NEXT(a_last_blocks, clk, rst, accept && frame.last_in_column, !frame.ready)

endmodule
